FILE: rtl/core/velocity_verlet_oscillator_step_unit_defines.svh
// assertion macros for the velocity verlet step unit
`ifndef VELOCITY_VERLET_OSCILLATOR_STEP_UNIT_DEFINES_SVH
`define VELOCITY_VERLET_OSCILLATOR_STEP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define VVO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be true outside reset
`define VVO_ASSERT_NEVER(label, cond, msg) \
    `VVO_ASSERT(label, !(cond), msg)

`else

`define VVO_ASSERT(label, prop, msg)
`define VVO_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: rtl/core/vvo_pkg.sv
// shared types and constants of the velocity verlet step unit
`default_nettype none

package vvo_pkg;

    // default geometry of the state
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // fraction bits of the step size register
    localparam int STEP_FRAC = 16;

    // product shifts: value times k or h, and value times h/2
    localparam int PROD_SHIFT = 16;
    localparam int HALF_SHIFT = PROD_SHIFT + 1;

    // register reset values: h = 66/65536, k = 100.0
    localparam logic [15:0] STEP_SIZE_RST  = 16'd66;
    localparam logic [31:0] FORCE_GAIN_RST = 32'd6553600;

    // configuration port
    localparam int ADDR_W      = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_STEP_SIZE  = 1'b0;
    localparam logic REG_FORCE_GAIN = 1'b1;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // limits of a 32-bit output field
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] init_coord;
        logic signed [31:0] init_position;
        logic signed [31:0] init_velocity;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] coord;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic              saturated;
    } rsp_t;

    // request to the shared multiplier
    typedef struct packed {
        logic start;
        logic half;
        logic negate;
    } mul_ctl_t;

    // status back from the shared multiplier
    typedef struct packed {
        logic done;
        logic sat;
    } mul_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/vvo_cfg_regs.sv
// configuration registers behind the apb-style port
`default_nettype none

module vvo_cfg_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vvo_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [15:0]                 step_size,
    output logic      [31:0]                 force_gain
);

    logic [15:0] step_size_reg;
    logic [15:0] step_size_next;
    logic [31:0] force_gain_reg;
    logic [31:0] force_gain_next;
    logic        reg_sel;
    logic        wr_en;

    assign reg_sel = paddr[vvo_pkg::REG_SEL_BIT];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write decode
    always_comb
    begin
        step_size_next  = step_size_reg;
        force_gain_next = force_gain_reg;
        if (wr_en)
        begin
            case (reg_sel)
                vvo_pkg::REG_STEP_SIZE:  step_size_next  = pwdata[15:0];
                vvo_pkg::REG_FORCE_GAIN: force_gain_next = pwdata;
                default:                 step_size_next  = step_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= vvo_pkg::STEP_SIZE_RST;
            force_gain_reg <= vvo_pkg::FORCE_GAIN_RST;
        end
        else
        begin
            step_size_reg  <= step_size_next;
            force_gain_reg <= force_gain_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            vvo_pkg::REG_STEP_SIZE:  prdata = {16'd0, step_size_reg};
            vvo_pkg::REG_FORCE_GAIN: prdata = force_gain_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    assign step_size  = step_size_reg;
    assign force_gain = force_gain_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vvo_mul_unit.sv
// shared saturating multiplier: signed value times unsigned 32-bit factor
`default_nettype none

module vvo_mul_unit #(
    parameter int DATA_WIDTH = vvo_pkg::DATA_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire vvo_pkg::mul_ctl_t            ctl,
    input  wire logic signed [DATA_WIDTH-1:0] a,
    input  wire logic        [31:0]           b,
    output logic signed      [DATA_WIDTH-1:0] res,
    output vvo_pkg::mul_sts_t                 sts
);

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = DW + 32;
    localparam int LO_W = (DW > 32) ? 32 : DW;

    localparam logic [DW-1:0] MAG_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MAG_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_LO   = 4'b0010,
        M_HI   = 4'b0100,
        M_FIN  = 4'b1000
    } mstate_t;

    mstate_t              state_reg;
    mstate_t              state_next;
    logic [DW-1:0]        mag_reg;
    logic [DW-1:0]        mag_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic                 half_reg;
    logic                 half_next;
    logic                 negate_reg;
    logic                 negate_next;
    logic [31:0]          b_reg;
    logic [31:0]          b_next;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic signed [DW-1:0] res_reg;
    logic signed [DW-1:0] res_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 sat_reg;
    logic                 sat_next;

    logic [LO_W+31:0]     lo_prod;
    logic [PW-1:0]        hi_add;
    logic [PW-1:0]        shifted;
    logic [PW-1:0]        limit;
    logic                 over;
    logic [DW-1:0]        r_mag;
    logic                 neg_edge;
    logic [DW-1:0]        r_out;

    // low partial product
    assign lo_prod = (LO_W+32)'(mag_reg[LO_W-1:0]) * (LO_W+32)'(b_reg);

    // high partial product, only for state wider than 32 bits
    generate
        if (DW > 32)
        begin : g_hi
            logic [DW-1:0] hi_prod;
            assign hi_prod = DW'(mag_reg[DW-1:32]) * DW'(b_reg);
            assign hi_add  = PW'(hi_prod) << 32;
        end
        else
        begin : g_no_hi
            assign hi_add = '0;
        end
    endgenerate

    // truncate, clamp to the signed range and restore the sign
    assign shifted  = half_reg ? (prod_reg >> vvo_pkg::HALF_SHIFT)
                               : (prod_reg >> vvo_pkg::PROD_SHIFT);
    assign limit    = PW'(MAG_MAX) + PW'(neg_reg);
    assign over     = shifted > limit;
    assign r_mag    = over ? limit[DW-1:0] : shifted[DW-1:0];
    assign neg_edge = neg_reg && negate_reg && (r_mag == MAG_MIN);
    assign r_out    = (neg_reg ^ negate_reg) ? (DW'(0) - r_mag) : r_mag;

    // sequencing of one product
    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        half_next   = half_reg;
        negate_next = negate_reg;
        b_next      = b_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        sat_next    = sat_reg;
        done_next   = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (ctl.start)
                begin
                    neg_next    = a[DW-1];
                    mag_next    = a[DW-1] ? (DW'(0) - $unsigned(a)) : $unsigned(a);
                    half_next   = ctl.half;
                    negate_next = ctl.negate;
                    b_next      = b;
                    state_next  = M_LO;
                end
            end
            M_LO:
            begin
                prod_next  = PW'(lo_prod);
                state_next = (DW > 32) ? M_HI : M_FIN;
            end
            M_HI:
            begin
                prod_next  = prod_reg + hi_add;
                state_next = M_FIN;
            end
            M_FIN:
            begin
                res_next   = neg_edge ? $signed(MAG_MAX) : $signed(r_out);
                sat_next   = over || neg_edge;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        half_reg   <= half_next;
        negate_reg <= negate_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        sat_reg    <= sat_next;
    end

    assign res      = res_reg;
    assign sts.done = done_reg;
    assign sts.sat  = sat_reg;

endmodule

`default_nettype wire

FILE: rtl/core/velocity_verlet_oscillator_step_unit.sv
// top level: sequencer, saturating adder and state of the verlet step unit
// step word: five dependent products on the shared multiplier
// load word: one word in flight, the next is taken while the previous result waits
//   in the output register
// reset: position, velocity and coordinate clear to zero, h = 66, k = 100.0
`default_nettype none
`include "velocity_verlet_oscillator_step_unit_defines.svh"

module velocity_verlet_oscillator_step_unit #(
    parameter int FRAC_BITS  = vvo_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = vvo_pkg::DATA_WIDTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire vvo_pkg::cmd_t               cmd,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output vvo_pkg::rsp_t                    rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vvo_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int DW    = DATA_WIDTH;
    localparam int CW    = ((DW > 32) ? DW : 32) + 1;
    localparam int INC_W = (FRAC_BITS > vvo_pkg::STEP_FRAC) ? FRAC_BITS : vvo_pkg::STEP_FRAC;
    localparam int EW    = INC_W + DW;

    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_COORD = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        PH_FORCE0 = 5'b00001,
        PH_HALF0  = 5'b00010,
        PH_POS    = 5'b00100,
        PH_FORCE1 = 5'b01000,
        PH_HALF1  = 5'b10000
    } phase_t;

    // clamp a 32-bit load value to the state range
    function automatic logic [DW:0] clamp_in(input logic signed [31:0] v);
        logic signed [CW-1:0] w;
        w = CW'(v);
        if (w > CW'(D_MAX))
            clamp_in = {1'b1, D_MAX};
        else if (w < CW'(D_MIN))
            clamp_in = {1'b1, D_MIN};
        else
            clamp_in = {1'b0, w[DW-1:0]};
    endfunction

    // clamp a state value to a 32-bit output field
    function automatic logic [32:0] clamp_out(input logic signed [DW-1:0] v);
        logic signed [CW-1:0] w;
        w = CW'(v);
        if (w > CW'(vvo_pkg::Q_MAX))
            clamp_out = {1'b1, vvo_pkg::Q_MAX};
        else if (w < CW'(vvo_pkg::Q_MIN))
            clamp_out = {1'b1, vvo_pkg::Q_MIN};
        else
            clamp_out = {1'b0, w[31:0]};
    endfunction

    // saturating add: flag on top, sum below
    function automatic logic [DW:0] add_sat(input logic signed [DW-1:0] x,
                                            input logic signed [DW-1:0] y);
        logic signed [DW:0] s;
        s = (DW+1)'(x) + (DW+1)'(y);
        if (s[DW] != s[DW-1])
            add_sat = s[DW] ? {1'b1, D_MIN} : {1'b1, D_MAX};
        else
            add_sat = {1'b0, s[DW-1:0]};
    endfunction

    state_t               state_reg;
    state_t               state_next;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic signed [DW-1:0] pos_reg;
    logic signed [DW-1:0] pos_next;
    logic signed [DW-1:0] vel_reg;
    logic signed [DW-1:0] vel_next;
    logic signed [DW-1:0] coord_reg;
    logic signed [DW-1:0] coord_next;
    logic signed [DW-1:0] tmp_reg;
    logic signed [DW-1:0] tmp_next;
    logic signed [DW-1:0] b_reg;
    logic signed [DW-1:0] b_next;
    logic                 sat_reg;
    logic                 sat_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    vvo_pkg::rsp_t        rsp_reg;
    vvo_pkg::rsp_t        rsp_next;

    logic [15:0]          step_size;
    logic [31:0]          force_gain;
    logic [INC_W-1:0]     inc_raw;
    logic                 inc_sat;
    logic signed [DW-1:0] inc_val;

    vvo_pkg::mul_ctl_t    mul_ctl;
    vvo_pkg::mul_sts_t    mul_sts;
    logic signed [DW-1:0] mul_a;
    logic [31:0]          mul_b;
    logic signed [DW-1:0] mul_res;

    logic signed [DW-1:0] add_x;
    logic signed [DW-1:0] add_y;
    logic [DW:0]          add_out;
    logic [DW:0]          ld_coord;
    logic [DW:0]          ld_pos;
    logic [DW:0]          ld_vel;
    logic [32:0]          out_coord;
    logic [32:0]          out_pos;
    logic [32:0]          out_vel;

    vvo_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .step_size  (step_size),
        .force_gain (force_gain)
    );

    vvo_mul_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .res   (mul_res),
        .sts   (mul_sts)
    );

    // coordinate increment: h moved to the state's fraction bits
    generate
        if (FRAC_BITS >= vvo_pkg::STEP_FRAC)
        begin : g_inc_up
            assign inc_raw = INC_W'(step_size) << (FRAC_BITS - vvo_pkg::STEP_FRAC);
        end
        else
        begin : g_inc_down
            assign inc_raw = INC_W'(step_size >> (vvo_pkg::STEP_FRAC - FRAC_BITS));
        end
    endgenerate

    assign inc_sat = EW'(inc_raw) > EW'($unsigned(D_MAX));
    assign inc_val = inc_sat ? D_MAX : $signed(DW'(inc_raw));

    // multiplier operands per phase
    always_comb
    begin
        mul_ctl.start = (state_reg == ST_ISSUE);
        case (phase_reg)
            PH_FORCE0, PH_FORCE1:
            begin
                mul_a          = pos_reg;
                mul_b          = force_gain;
                mul_ctl.half   = 1'b0;
                mul_ctl.negate = 1'b1;
            end
            PH_HALF0, PH_HALF1:
            begin
                mul_a          = tmp_reg;
                mul_b          = {16'd0, step_size};
                mul_ctl.half   = 1'b1;
                mul_ctl.negate = 1'b0;
            end
            PH_POS:
            begin
                mul_a          = b_reg;
                mul_b          = {16'd0, step_size};
                mul_ctl.half   = 1'b0;
                mul_ctl.negate = 1'b0;
            end
            default:
            begin
                mul_a          = pos_reg;
                mul_b          = force_gain;
                mul_ctl.half   = 1'b0;
                mul_ctl.negate = 1'b1;
            end
        endcase
    end

    // adder operands: state update per phase, or the coordinate
    always_comb
    begin
        add_y = tmp_reg;
        if (state_reg == ST_COORD)
        begin
            add_x = coord_reg;
            add_y = inc_val;
        end
        else
        begin
            case (phase_reg)
                PH_HALF0: add_x = vel_reg;
                PH_POS:   add_x = pos_reg;
                default:  add_x = b_reg;
            endcase
        end
    end

    assign add_out = add_sat(add_x, add_y);

    // load clamps and output clamps
    assign ld_coord  = clamp_in(cmd.init_coord);
    assign ld_pos    = clamp_in(cmd.init_position);
    assign ld_vel    = clamp_in(cmd.init_velocity);
    assign out_coord = clamp_out(coord_reg);
    assign out_pos   = clamp_out(pos_reg);
    assign out_vel   = clamp_out(vel_reg);

    assign cmd_ready = (state_reg == ST_IDLE);

    // step sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        coord_next     = coord_reg;
        tmp_next       = tmp_reg;
        b_next         = b_reg;
        sat_next       = sat_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.operation == vvo_pkg::OP_LOAD)
                    begin
                        coord_next = $signed(ld_coord[DW-1:0]);
                        pos_next   = $signed(ld_pos[DW-1:0]);
                        vel_next   = $signed(ld_vel[DW-1:0]);
                        sat_next   = ld_coord[DW] || ld_pos[DW] || ld_vel[DW];
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sat_next   = 1'b0;
                        phase_next = PH_FORCE0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_sts.done)
                begin
                    tmp_next = mul_res;
                    sat_next = sat_reg || mul_sts.sat;
                    case (phase_reg)
                        PH_FORCE0:
                        begin
                            phase_next = PH_HALF0;
                            state_next = ST_ISSUE;
                        end
                        PH_FORCE1:
                        begin
                            phase_next = PH_HALF1;
                            state_next = ST_ISSUE;
                        end
                        default:
                        begin
                            state_next = ST_ADD;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                sat_next = sat_reg || add_out[DW];
                case (phase_reg)
                    PH_HALF0:
                    begin
                        b_next     = $signed(add_out[DW-1:0]);
                        phase_next = PH_POS;
                        state_next = ST_ISSUE;
                    end
                    PH_POS:
                    begin
                        pos_next   = $signed(add_out[DW-1:0]);
                        phase_next = PH_FORCE1;
                        state_next = ST_ISSUE;
                    end
                    default:
                    begin
                        vel_next   = $signed(add_out[DW-1:0]);
                        state_next = ST_COORD;
                    end
                endcase
            end
            ST_COORD:
            begin
                coord_next = $signed(add_out[DW-1:0]);
                sat_next   = sat_reg || add_out[DW] || inc_sat;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.coord     = out_coord[31:0];
                    rsp_next.position  = out_pos[31:0];
                    rsp_next.velocity  = out_vel[31:0];
                    rsp_next.saturated = sat_reg || out_coord[32] || out_pos[32]
                                         || out_vel[32];
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and integrator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FORCE0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            coord_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            coord_reg     <= coord_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // intermediates and output word
    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        b_reg   <= b_next;
        sat_reg <= sat_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `VVO_ASSERT(a_mul_done_in_wait, mul_sts.done |-> (state_reg == ST_WAIT),
                "product finished outside wait state")
    `VVO_ASSERT(a_step_starts_mul,
                (cmd_valid && cmd_ready && (cmd.operation == vvo_pkg::OP_STEP))
                |=> (state_reg == ST_ISSUE),
                "step word did not start a product")
    `VVO_ASSERT(a_done_holds,
                ((state_reg == ST_DONE) && rsp_valid && !rsp_ready) |=> (state_reg == ST_DONE),
                "result left while output register full")
    `VVO_ASSERT_NEVER(a_no_add_in_force,
                      (state_reg == ST_ADD)
                      && ((phase_reg == PH_FORCE0) || (phase_reg == PH_FORCE1)),
                      "state update during a force phase")

endmodule

`default_nettype wire
